/* rtl/fdc_pkg.sv */
// ----------------------------------------------------------------------------
// fdc_pkg
// shared types and constants of the crc16 frame decoder
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam int unsigned COUNT_W = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd6;
    localparam logic [15:0]        CRC_INIT       = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY       = 16'h1021;
    localparam logic [15:0]        CRC_TOP        = 16'h8000;

    localparam logic [7:0]  START_BYTE_RESET       = 8'hAA;
    localparam logic [15:0] MAX_PAYLOAD_RESET      = 16'd256;
    localparam logic [15:0] PAYLOAD_CAPACITY_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_START_BYTE       = 2'd0,
        CFG_MAX_PAYLOAD      = 2'd1,
        CFG_PAYLOAD_CAPACITY = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        FS_OK         = 3'd0,
        FS_TOO_SHORT  = 3'd1,
        FS_BAD_START  = 3'd2,
        FS_BAD_LENGTH = 3'd3,
        FS_BAD_CRC    = 3'd4
    } frame_status_t;

    typedef enum logic {
        RK_PAYLOAD = 1'b0,
        RK_STATUS  = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_payload;
        logic [15:0] payload_capacity;
    } cfg_t;

    typedef struct packed {
        logic          valid;
        result_kind_t  kind;
        logic [7:0]    payload_byte;
        logic [7:0]    frame_type;
        logic [15:0]   payload_length;
        frame_status_t status;
    } result_t;

endpackage

/* rtl/crc16_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// crc16_frame_decoder_core
// streaming decoder for sof / type / length / payload / crc-16 frames
// ----------------------------------------------------------------------------
// latency: a result is valid the cycle after its input byte is accepted
// throughput: one byte per cycle while the result register is empty or being drained, set by the single result register
// in_ready stays high while the result register is empty or being drained
// reset clears the frame state and loads the register defaults
// ----------------------------------------------------------------------------
module crc16_frame_decoder_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_frame,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  frame_type,
    output logic [15:0] payload_length,
    output logic [2:0]  frame_status
);

    fdc_pkg::cfg_t    cfg_reg;
    fdc_pkg::result_t res;
    fdc_pkg::result_t res_reg;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte       <= fdc_pkg::START_BYTE_RESET;
            cfg_reg.max_payload      <= fdc_pkg::MAX_PAYLOAD_RESET;
            cfg_reg.payload_capacity <= fdc_pkg::PAYLOAD_CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fdc_pkg::CFG_START_BYTE:       cfg_reg.start_byte       <= cfg_data[7:0];
                fdc_pkg::CFG_MAX_PAYLOAD:      cfg_reg.max_payload      <= cfg_data;
                fdc_pkg::CFG_PAYLOAD_CAPACITY: cfg_reg.payload_capacity <= cfg_data;
                default:                       ;
            endcase
        end
    end

    fdc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_fire),
        .rx_byte (rx_byte),
        .last    (end_of_frame),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = res.valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res.valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = res_reg.kind;
    assign payload_byte   = res_reg.payload_byte;
    assign frame_type     = res_reg.frame_type;
    assign payload_length = res_reg.payload_length;
    assign frame_status   = res_reg.status;

`ifndef SYNTHESIS
    a_payload_status_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.kind == fdc_pkg::RK_PAYLOAD
        |-> res_reg.status == fdc_pkg::FS_OK)
        else $error("payload transaction carries a status");

    a_status_zero_byte: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.kind == fdc_pkg::RK_STATUS
        |-> res_reg.payload_byte == 8'h00)
        else $error("status transaction carries a payload byte");

    a_hold_while_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled transaction changed before acceptance");
`endif

endmodule

/* rtl/fdc_crc_byte.sv */
// ----------------------------------------------------------------------------
// fdc_crc_byte
// bytewise crc-16/ccitt-false update, msb first
// ----------------------------------------------------------------------------
module fdc_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & fdc_pkg::CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ fdc_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

/* rtl/fdc_parser.sv */
// ----------------------------------------------------------------------------
// fdc_parser
// frame position tracking, header capture, crc accumulation and status check
// ----------------------------------------------------------------------------
module fdc_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic                 last,
    input  fdc_pkg::cfg_t        cfg,
    output fdc_pkg::result_t     res
);

    logic [fdc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [15:0]                 crc_reg, crc_next;
    logic                        start_ok_reg, start_ok_next;
    logic [7:0]                  type_reg, type_next;
    logic [15:0]                 length_reg, length_next;
    logic [15:0]                 rxcrc_reg, rxcrc_next;

    logic [15:0]                 crc_upd;
    logic                        crc_en;
    logic                        is_payload;
    logic [fdc_pkg::COUNT_W-1:0] len_ext;
    logic [fdc_pkg::COUNT_W-1:0] n_bytes;
    fdc_pkg::frame_status_t      status;

    fdc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    assign len_ext = {1'b0, length_reg};

    always_comb
    begin
        start_ok_next = start_ok_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        rxcrc_next    = rxcrc_reg;
        crc_en        = 1'b0;
        is_payload    = 1'b0;
        if (count_reg == 17'd0)
        begin
            start_ok_next = (rx_byte == cfg.start_byte);
        end
        else if (count_reg == 17'd1)
        begin
            type_next = rx_byte;
            crc_en    = 1'b1;
        end
        else if (count_reg == 17'd2)
        begin
            length_next = {length_reg[15:8], rx_byte};
            crc_en      = 1'b1;
        end
        else if (count_reg == 17'd3)
        begin
            length_next = {rx_byte, length_reg[7:0]};
            crc_en      = 1'b1;
        end
        else if (count_reg < len_ext + 17'd4)
        begin
            crc_en     = 1'b1;
            is_payload = 1'b1;
        end
        else if (count_reg == len_ext + 17'd4)
        begin
            rxcrc_next = {rxcrc_reg[15:8], rx_byte};
        end
        else if (count_reg == len_ext + 17'd5)
        begin
            rxcrc_next = {rx_byte, rxcrc_reg[7:0]};
        end
        crc_next = crc_en ? crc_upd : crc_reg;
    end

    // byte count of the frame including the current byte
    assign n_bytes = (count_reg < fdc_pkg::COUNT_MAX) ? count_reg + 17'd1
                                                      : fdc_pkg::COUNT_MAX;

    always_comb
    begin
        if (n_bytes < fdc_pkg::FRAME_OVERHEAD)
        begin
            status = fdc_pkg::FS_TOO_SHORT;
        end
        else if (!start_ok_next)
        begin
            status = fdc_pkg::FS_BAD_START;
        end
        else if (length_next > cfg.max_payload)
        begin
            status = fdc_pkg::FS_BAD_LENGTH;
        end
        else if (n_bytes < {1'b0, length_next} + fdc_pkg::FRAME_OVERHEAD)
        begin
            status = fdc_pkg::FS_TOO_SHORT;
        end
        else if (crc_next != rxcrc_next)
        begin
            status = fdc_pkg::FS_BAD_CRC;
        end
        else if (length_next > cfg.payload_capacity)
        begin
            status = fdc_pkg::FS_BAD_LENGTH;
        end
        else
        begin
            status = fdc_pkg::FS_OK;
        end
    end

    always_comb
    begin
        res.valid          = last || is_payload;
        res.kind           = last ? fdc_pkg::RK_STATUS : fdc_pkg::RK_PAYLOAD;
        res.payload_byte   = last ? 8'h00 : rx_byte;
        res.frame_type     = type_next;
        res.payload_length = length_next;
        res.status         = last ? status : fdc_pkg::FS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            crc_reg      <= fdc_pkg::CRC_INIT;
            start_ok_reg <= 1'b0;
            type_reg     <= '0;
            length_reg   <= '0;
            rxcrc_reg    <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                count_reg    <= '0;
                crc_reg      <= fdc_pkg::CRC_INIT;
                start_ok_reg <= 1'b0;
                type_reg     <= '0;
                length_reg   <= '0;
                rxcrc_reg    <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                start_ok_reg <= start_ok_next;
                type_reg     <= type_next;
                length_reg   <= length_next;
                rxcrc_reg    <= rxcrc_next;
            end
        end
    end

    assign count_next = (count_reg < fdc_pkg::COUNT_MAX) ? count_reg + 17'd1 : count_reg;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && last |=> count_reg == 17'd0 && crc_reg == fdc_pkg::CRC_INIT
                         && !start_ok_reg)
        else $error("frame state not cleared after final byte");

    a_count_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && !last && count_reg != fdc_pkg::COUNT_MAX
        |=> count_reg == $past(count_reg) + 17'd1)
        else $error("byte count did not advance");

    a_hold_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        !step |=> $stable(count_reg) && $stable(crc_reg) && $stable(length_reg))
        else $error("frame state changed without a transaction");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the crc16 frame decoder core: frames are streamed
// byte by byte against an in-bench predictor, first a short directed
// table, then one long frame with trailing bytes, then random frame traffic
// under several register settings and handshake idle patterns
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_PERIOD   = 8;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_BYTES  = 295;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned LONG_LEN     = 120;
    localparam int unsigned LONG_BYTES   = LONG_LEN + 10;
    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        fdc_pkg::result_kind_t  kind;
        logic [7:0]             payload_byte;
        logic [7:0]             frame_type;
        logic [15:0]            payload_length;
        fdc_pkg::frame_status_t status;
    } frame_result_t;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI
    } byte_src_t;

    typedef struct packed {
        byte_src_t     src;
        logic [7:0]    value;
        logic          last;
        logic          given;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT =
        '{fdc_pkg::RK_PAYLOAD, 8'h00, 8'h00, 16'h0000, fdc_pkg::FS_OK};

    localparam stim_row_t DIRECTED [22] = '{
        '{SRC_LIT,    8'hAA, 1'b1, 1'b1,
          '{fdc_pkg::RK_STATUS, 8'h00, 8'h00, 16'h0000, fdc_pkg::FS_TOO_SHORT}},
        '{SRC_LIT,    8'h55, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b1, 1'b1,
          '{fdc_pkg::RK_STATUS, 8'h00, 8'h01, 16'h0000, fdc_pkg::FS_BAD_START}},
        '{SRC_LIT,    8'hAA, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h02, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h7E, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b1, 1'b1,
          '{fdc_pkg::RK_STATUS, 8'h00, 8'h02, 16'h0101, fdc_pkg::FS_BAD_LENGTH}},
        '{SRC_LIT,    8'hAA, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
        '{SRC_LIT,    8'hFF, 1'b1, 1'b1,
          '{fdc_pkg::RK_STATUS, 8'h00, 8'hFF, 16'h0001, fdc_pkg::FS_OK}}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = 2'd0;
    logic [15:0] cfg_data     = 16'h0000;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte      = 8'h00;
    logic        end_of_frame = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [2:0]  frame_status;

    // register copies and per-frame decoder state of the predictor
    logic [7:0]  reg_sof;
    logic [15:0] reg_max;
    logic [15:0] reg_cap;
    int unsigned dec_count;
    logic [15:0] dec_crc;
    logic        dec_sof_ok;
    logic [7:0]  dec_type;
    logic [15:0] dec_len;
    logic [15:0] dec_crc_rx;

    frame_result_t expected_q [$];
    int unsigned   error_count    = 0;
    int unsigned   sent_bytes     = 0;
    int unsigned   cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    logic          hold_go        = 1'b0;
    logic          hold_off       = 1'b0;

    crc16_frame_decoder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .end_of_frame   (end_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .frame_type     (frame_type),
        .payload_length (payload_length),
        .frame_status   (frame_status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = (c & fdc_pkg::CRC_TOP) != 0 ? ((c << 1) ^ fdc_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void clear_decoder();
        dec_count  = 0;
        dec_crc    = fdc_pkg::CRC_INIT;
        dec_sof_ok = 1'b0;
        dec_type   = 8'h00;
        dec_len    = 16'h0000;
        dec_crc_rx = 16'h0000;
    endfunction

    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output frame_result_t res);
        int unsigned            pos;
        int unsigned            len;
        int unsigned            n;
        bit                     is_payload;
        fdc_pkg::frame_status_t st;
        pos        = dec_count;
        len        = dec_len;
        is_payload = 1'b0;
        res        = NO_RESULT;
        if (pos == 0)
        begin
            dec_sof_ok = (b == reg_sof);
        end
        else if (pos == 1)
        begin
            dec_type = b;
            dec_crc  = crc16_step(dec_crc, b);
        end
        else if (pos == 2)
        begin
            dec_len[7:0] = b;
            dec_crc      = crc16_step(dec_crc, b);
        end
        else if (pos == 3)
        begin
            dec_len[15:8] = b;
            dec_crc       = crc16_step(dec_crc, b);
        end
        else if (pos < 4 + len)
        begin
            dec_crc    = crc16_step(dec_crc, b);
            is_payload = 1'b1;
        end
        else if (pos == 4 + len)
        begin
            dec_crc_rx[7:0] = b;
        end
        else if (pos == 5 + len)
        begin
            dec_crc_rx[15:8] = b;
        end

        if (!last)
        begin
            if (dec_count < fdc_pkg::COUNT_MAX)
                dec_count++;
            if (!is_payload)
                return 1'b0;
            res = '{fdc_pkg::RK_PAYLOAD, b, dec_type, dec_len, fdc_pkg::FS_OK};
            return 1'b1;
        end

        n   = (pos < fdc_pkg::COUNT_MAX) ? pos + 1 : fdc_pkg::COUNT_MAX;
        len = dec_len;
        if (n < fdc_pkg::FRAME_OVERHEAD)
            st = fdc_pkg::FS_TOO_SHORT;
        else if (!dec_sof_ok)
            st = fdc_pkg::FS_BAD_START;
        else if (len > reg_max)
            st = fdc_pkg::FS_BAD_LENGTH;
        else if (n < fdc_pkg::FRAME_OVERHEAD + len)
            st = fdc_pkg::FS_TOO_SHORT;
        else if (dec_crc != dec_crc_rx)
            st = fdc_pkg::FS_BAD_CRC;
        else if (len > reg_cap)
            st = fdc_pkg::FS_BAD_LENGTH;
        else
            st = fdc_pkg::FS_OK;
        res = '{fdc_pkg::RK_STATUS, 8'h00, dec_type, dec_len, st};
        clear_decoder();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last,
                             input bit use_given, input frame_result_t given);
        frame_result_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        end_of_frame <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sent_bytes++;
        if (predict_byte(b, last, res))
            expected_q.push_back(use_given ? given : res);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            fdc_pkg::CFG_START_BYTE:       reg_sof = value[7:0];
            fdc_pkg::CFG_MAX_PAYLOAD:      reg_max = value;
            fdc_pkg::CFG_PAYLOAD_CAPACITY: reg_cap = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_length();
        case ($urandom_range(9))
            7: return (reg_max <= 40) ? reg_max : 16'($urandom_range(0, 8));
            8: return (reg_max < 40) ? reg_max + 16'd1 : 16'($urandom_range(0, 8));
            9: return (reg_cap < 40) ? reg_cap + 16'($urandom_range(0, 1))
                                     : 16'($urandom_range(0, 8));
            default: return 16'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic send_frame();
        logic [7:0]  fb [$];
        logic [15:0] len;
        logic [15:0] crc;
        int unsigned kind;
        int unsigned body;
        int unsigned cut;
        kind = $urandom_range(99);
        if (kind >= 90)
        begin
            repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
        end
        else
        begin
            len  = (kind >= 82) ? 16'($urandom) : pick_length();
            body = (kind >= 82) ? $urandom_range(0, 4) : len;
            fb.push_back(reg_sof);
            fb.push_back(8'($urandom));
            fb.push_back(len[7:0]);
            fb.push_back(len[15:8]);
            repeat (body) fb.push_back(8'($urandom));
            crc = fdc_pkg::CRC_INIT;
            for (int i = 1; i < fb.size(); i++)
                crc = crc16_step(crc, fb[i]);
            if (kind >= 65 && kind < 73)
                crc = crc ^ 16'($urandom_range(1, 65535));
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            if (kind >= 57 && kind < 65)
                fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            if (kind >= 73 && kind < 82)
            begin
                cut = $urandom_range(1, fb.size() - 1);
                fb  = fb[0:cut-1];
            end
            if (kind < 57 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
        end
        foreach (fb[i])
            push_byte(fb[i], i == fb.size() - 1, 1'b0, NO_RESULT);
    endtask

    // long payload frame followed by a few trailing bytes
    task automatic send_long_frame();
        logic [15:0] crc;
        logic [7:0]  b;
        crc = fdc_pkg::CRC_INIT;
        for (int unsigned pos = 0; pos < LONG_BYTES; pos++)
        begin
            if (pos == 0)
                b = reg_sof;
            else if (pos == 1)
                b = 8'h3C;
            else if (pos == 2)
                b = 8'(LONG_LEN);
            else if (pos == 3)
                b = 8'(LONG_LEN >> 8);
            else if (pos < 4 + LONG_LEN)
                b = 8'($urandom);
            else if (pos == 4 + LONG_LEN)
                b = crc[7:0];
            else if (pos == 5 + LONG_LEN)
                b = crc[15:8];
            else
                b = 8'($urandom);
            if (pos >= 1 && pos < 4 + LONG_LEN)
                crc = crc16_step(crc, b);
            push_byte(b, pos == LONG_BYTES - 1, 1'b0, NO_RESULT);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input logic [7:0] sof, input logic [15:0] maxp,
                             input logic [15:0] cap, input bit stray, input bit press);
        int unsigned first;
        write_reg(fdc_pkg::CFG_START_BYTE, {8'h00, sof});
        write_reg(fdc_pkg::CFG_MAX_PAYLOAD, maxp);
        write_reg(fdc_pkg::CFG_PAYLOAD_CAPACITY, cap);
        if (stray)
            write_reg(CFG_UNMAPPED, 16'h0001);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        if (press)
            hold_go = 1'b1;
        first = sent_bytes;
        while (sent_bytes - first < PHASE_BYTES)
            send_frame();
    endtask

    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction kind %0d type 0x%0h",
                                          result_kind, frame_type));
            end
            else
            begin
                want = expected_q.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch($sformatf("result_kind got %0d expected %0d",
                                              result_kind, want.kind));
                if (payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte got 0x%0h expected 0x%0h",
                                              payload_byte, want.payload_byte));
                if (frame_type !== want.frame_type)
                    report_mismatch($sformatf("frame_type got 0x%0h expected 0x%0h",
                                              frame_type, want.frame_type));
                if (payload_length !== want.payload_length)
                    report_mismatch($sformatf("payload_length got 0x%0h expected 0x%0h",
                                              payload_length, want.payload_length));
                if (frame_status !== want.status)
                    report_mismatch($sformatf("frame_status got %0d expected %0d",
                                              frame_status, want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] b;
        reg_sof = fdc_pkg::START_BYTE_RESET;
        reg_max = fdc_pkg::MAX_PAYLOAD_RESET;
        reg_cap = fdc_pkg::PAYLOAD_CAPACITY_RESET;
        clear_decoder();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            case (DIRECTED[i].src)
                SRC_CRC_LO: b = dec_crc[7:0];
                SRC_CRC_HI: b = dec_crc[15:8];
                default:    b = DIRECTED[i].value;
            endcase
            push_byte(b, DIRECTED[i].last, DIRECTED[i].given, DIRECTED[i].want);
        end

        write_reg(fdc_pkg::CFG_MAX_PAYLOAD, 16'hFFFF);
        send_long_frame();

        run_phase(0, 0, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
        run_phase(88, 0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        run_phase(0, 88, 8'h5A, 16'd24, 16'd16, 1'b0, 1'b1);
        run_phase(25, 25, 8'hAA, 16'd40, 16'd8, 1'b0, 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
